>>> design/sed_pkg.sv
// Shared constants, types and level tables for the serpentine RGB332 dither block.
`timescale 1ns / 1ps

package sed_pkg;

  localparam int MAX_LINE_WIDTH = 1024;
  localparam int ERROR_BITS     = 14;
  localparam int CFG_BITS       = 11;
  localparam int COLUMN_BITS    = 10;
  localparam logic [CFG_BITS-1:0] LINE_WIDTH_RESET = 11'd640;

  // Per-pixel flags that steer one channel datapath.
  typedef struct packed {
    logic fresh;       // errors from the row above read as zero
    logic line_start;  // first pixel of a line: carry and pending-ahead sum cleared
  } chan_ctl_t;

  // Reproduced value of a red or green level: k*255/7, truncated.
  function automatic logic [7:0] rg_value(input logic [2:0] lvl);
    logic [7:0] v;
    case (lvl)
      3'd0: v = 8'd0;
      3'd1: v = 8'd36;
      3'd2: v = 8'd72;
      3'd3: v = 8'd109;
      3'd4: v = 8'd145;
      3'd5: v = 8'd182;
      3'd6: v = 8'd218;
      3'd7: v = 8'd255;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // Reproduced value of a blue level: k*255/3.
  function automatic logic [7:0] b_value(input logic [1:0] lvl);
    logic [7:0] v;
    case (lvl)
      2'd0: v = 8'd0;
      2'd1: v = 8'd85;
      2'd2: v = 8'd170;
      2'd3: v = 8'd255;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

>>> design/sed_ram.sv
// Simple dual-port error line RAM with registered, write-first read.
`timescale 1ns / 1ps

module sed_ram #(
  parameter int ADDR_BITS = 10,
  parameter int DATA_BITS = 42
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A read that meets a write in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

>>> design/sed_channel.sv
// One color channel: error add, quantize and Floyd-Steinberg error split.
`timescale 1ns / 1ps

module sed_channel #(
  parameter int ERROR_BITS = sed_pkg::ERROR_BITS,
  parameter bit BLUE       = 1'b0
) (
  input  logic                               [7:0] pix,
  input  sed_pkg::chan_ctl_t                       ctl,
  input  logic signed [ERROR_BITS-1:0]             stored_err,
  input  logic signed [ERROR_BITS-1:0]             carry,
  input  logic signed [ERROR_BITS-3:0]             pend_ahead,
  input  logic signed [ERROR_BITS:0]               pend_behind,
  output logic                               [2:0] level,
  output logic signed [ERROR_BITS-1:0]             carry_next,
  output logic signed [ERROR_BITS-3:0]             pend_ahead_next,
  output logic signed [ERROR_BITS:0]               pend_behind_next,
  output logic signed [ERROR_BITS-1:0]             behind_err,
  output logic signed [ERROR_BITS-1:0]             below_err
);

  // t and q width, partial below-sum width, and a roomy work width.
  localparam int TW = ERROR_BITS - 2;
  localparam int PW = TW + 3;
  localparam int WW = ERROR_BITS + 4;

  localparam logic signed [WW-1:0] SAT_HI = WW'((1 << (ERROR_BITS - 1)) - 1);
  localparam logic signed [WW-1:0] SAT_LO = -SAT_HI - WW'(1);
  localparam logic signed [TW-1:0] T_MAX  = TW'(255);

  function automatic logic signed [ERROR_BITS-1:0] sat(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] c;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end else begin
      c = v;
    end
    return c[ERROR_BITS-1:0];
  endfunction

  logic signed [ERROR_BITS-1:0] e_in;
  logic signed [ERROR_BITS-1:0] c_in;
  logic signed [TW-1:0]         pa_in;
  logic signed [ERROR_BITS-1:0] e;
  logic signed [ERROR_BITS:0]   e_round;
  logic signed [TW-1:0]         t;
  logic                   [7:0] act;
  logic signed [TW-1:0]         q;
  logic signed [WW-1:0]         q_w;
  logic signed [WW-1:0]         p0_w;

  always_comb begin
    e_in  = ctl.fresh ? '0 : stored_err;
    c_in  = ctl.line_start ? '0 : carry;
    pa_in = ctl.line_start ? '0 : pend_ahead;

    e       = sat(WW'(e_in) + WW'(c_in));
    // floor((e + 8) / 16)
    e_round = ((ERROR_BITS + 1)'(e) + (ERROR_BITS + 1)'(8)) >>> 4;
    t       = TW'(e_round) + signed'(TW'(pix));

    if (t < 0) begin
      level = 3'd0;
    end else if (t > T_MAX) begin
      level = BLUE ? 3'd3 : 3'd7;
    end else if (BLUE) begin
      level = {1'b0, t[7:6]};
    end else begin
      level = t[7:5];
    end

    act = BLUE ? sed_pkg::b_value(level[1:0]) : sed_pkg::rg_value(level);
    q   = t - signed'(TW'(act));
    q_w = WW'(q);

    carry_next       = sat(q_w * WW'(7));
    p0_w             = WW'(pa_in) + q_w * WW'(5);
    behind_err       = sat(WW'(pend_behind) + q_w * WW'(3));
    below_err        = sat(p0_w);
    pend_ahead_next  = q;
    pend_behind_next = PW'(p0_w);
  end

endmodule

>>> design/serpentine_error_diffusion_rgb332.sv
// Top level of the serpentine Floyd-Steinberg RGB332 dither block.
`timescale 1ns / 1ps

// One pixel per clock in steady flow, while the output is taken: a pixel is
// taken into the stage register with its line-store read, its error is
// resolved there combinationally, and its palette index lands in the output
// register when the stage advances. The loop that bounds the rate is the
// right-hand error carry, closed through one register. The line stores live
// in two RAMs split by column parity, so the two writes a line-end pixel
// makes never meet on one port. After reset the block sweeps every address
// of the stores to zero and takes no pixel meanwhile; line_width writes are
// taken throughout. Writing line_width restarts the line position at column
// zero.
module serpentine_error_diffusion_rgb332 #(
  parameter int MAX_LINE_WIDTH = sed_pkg::MAX_LINE_WIDTH,
  parameter int ERROR_BITS     = sed_pkg::ERROR_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [sed_pkg::CFG_BITS-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                       [7:0] red,
  input  logic                       [7:0] green,
  input  logic                       [7:0] blue,
  input  logic                             row_odd,
  input  logic                             new_image,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                       [7:0] palette_index,
  output logic [sed_pkg::COLUMN_BITS-1:0]  column,
  output logic                             last_in_line
);

  localparam int CW    = $clog2(MAX_LINE_WIDTH);
  localparam int HALF  = (MAX_LINE_WIDTH + 1) / 2;
  localparam int HW    = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int AW    = HW + 1;
  localparam int TW    = ERROR_BITS - 2;
  localparam int PW    = TW + 3;
  localparam int DW    = 3 * ERROR_BITS;
  localparam int COLW  = sed_pkg::COLUMN_BITS;
  localparam logic [AW-1:0] CLR_LAST = {AW{1'b1}};

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  typedef struct packed {
    logic [7:0]    r;
    logic [7:0]    g;
    logic [7:0]    b;
    logic          odd;
    logic          fresh;
    logic          first;
    logic          last;
    logic [CW-1:0] x;
    logic [CW-1:0] behind;
  } stage_t;

  state_t                       state;
  logic [AW-1:0]                clr_cnt;
  logic [sed_pkg::CFG_BITS-1:0] line_width;
  logic [CW-1:0]                pixel_count;
  logic [CW-1:0]                pixel_count_next;

  logic                         s1_valid;
  stage_t                       s1;
  stage_t                       s1_next;
  logic                         s1_adv;
  logic                         accept;

  logic [31:0]                  lw32;
  logic [CW:0]                  eff_w;
  logic [CW:0]                  lx_w;
  logic [CW-1:0]                lx;
  logic [CW-1:0]                x_in;
  logic [HW-1:0]                rd_half;
  logic [CW-1:0]                x_half;
  logic [CW-1:0]                b_half;
  logic [CW-1:0]                x_shift;
  logic [CW-1:0]                b_shift;

  logic [DW-1:0]                rd_data [2];
  logic [DW-1:0]                stored;
  logic                         wr_en   [2];
  logic [AW-1:0]                wr_addr [2];
  logic [DW-1:0]                wr_data [2];

  logic signed [ERROR_BITS-1:0] carry            [3];
  logic signed [TW-1:0]         pend_ahead       [3];
  logic signed [PW-1:0]         pend_behind      [3];
  logic signed [ERROR_BITS-1:0] carry_next       [3];
  logic signed [TW-1:0]         pend_ahead_next  [3];
  logic signed [PW-1:0]         pend_behind_next [3];
  logic signed [ERROR_BITS-1:0] behind_err       [3];
  logic signed [ERROR_BITS-1:0] below_err        [3];
  logic                   [2:0] level            [3];
  logic                   [7:0] pix              [3];
  logic [DW-1:0]                behind_word;
  logic [DW-1:0]                below_word;
  logic [CW+COLW-1:0]           col_ext;
  sed_pkg::chan_ctl_t           ctl;

  // Line geometry of the pixel at the input.
  always_comb begin
    lw32 = 32'(line_width);
    if (lw32 == 32'd0) begin
      eff_w = (CW + 1)'(1);
    end else if (lw32 > 32'(MAX_LINE_WIDTH)) begin
      eff_w = (CW + 1)'(MAX_LINE_WIDTH);
    end else begin
      eff_w = lw32[CW:0];
    end

    lx_w = ((CW + 1)'(pixel_count) >= eff_w) ? '0 : (CW + 1)'(pixel_count);
    lx   = lx_w[CW-1:0];
    x_in = row_odd ? CW'(eff_w - (CW + 1)'(1) - lx_w) : lx;

    s1_next.r      = red;
    s1_next.g      = green;
    s1_next.b      = blue;
    s1_next.odd    = row_odd;
    s1_next.fresh  = new_image;
    s1_next.first  = (lx_w == '0);
    s1_next.last   = (lx_w == eff_w - (CW + 1)'(1));
    s1_next.x      = x_in;
    s1_next.behind = row_odd ? x_in + CW'(1) : x_in - CW'(1);

    pixel_count_next = s1_next.last ? '0 : CW'(lx_w + (CW + 1)'(1));

    x_shift = x_in >> 1;
    rd_half = x_shift[HW-1:0];
  end

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = (state == ST_RUN) && (!s1_valid || s1_adv);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == CLR_LAST) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          state <= ST_RUN;
        end
        default: begin
          state   <= ST_CLEAR;
          clr_cnt <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width  <= sed_pkg::LINE_WIDTH_RESET;
      pixel_count <= '0;
    end else if (cfg_we) begin
      line_width  <= cfg_data;
      pixel_count <= '0;
    end else if (accept) begin
      pixel_count <= pixel_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

  // Error line stores, even and odd columns apart; the row parity picks the half.
  for (genvar p = 0; p < 2; p++) begin : g_ram
    sed_ram #(
      .ADDR_BITS(AW),
      .DATA_BITS(DW)
    ) u_ram (
      .clk  (clk),
      .we   (wr_en[p]),
      .waddr(wr_addr[p]),
      .wdata(wr_data[p]),
      .re   (accept),
      .raddr({row_odd, rd_half}),
      .rdata(rd_data[p])
    );
  end

  assign stored = s1.x[0] ? rd_data[1] : rd_data[0];

  assign ctl.fresh      = s1.fresh;
  assign ctl.line_start = s1.first;
  assign pix[0] = s1.r;
  assign pix[1] = s1.g;
  assign pix[2] = s1.b;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    sed_channel #(
      .ERROR_BITS(ERROR_BITS),
      .BLUE      (c == 2)
    ) u_chan (
      .pix             (pix[c]),
      .ctl             (ctl),
      .stored_err      (stored[DW-1-c*ERROR_BITS -: ERROR_BITS]),
      .carry           (carry[c]),
      .pend_ahead      (pend_ahead[c]),
      .pend_behind     (pend_behind[c]),
      .level           (level[c]),
      .carry_next      (carry_next[c]),
      .pend_ahead_next (pend_ahead_next[c]),
      .pend_behind_next(pend_behind_next[c]),
      .behind_err      (behind_err[c]),
      .below_err       (below_err[c])
    );
  end

  assign behind_word = {behind_err[0], behind_err[1], behind_err[2]};
  assign below_word  = {below_err[0], below_err[1], below_err[2]};

  // Write ports: clearing sweep, then the below-behind and line-end writes.
  // The two writes of one pixel sit in adjacent columns, so in different RAMs.
  always_comb begin
    x_half = s1.x >> 1;
    b_half = s1.behind >> 1;
    for (int p = 0; p < 2; p++) begin
      if (state == ST_CLEAR) begin
        wr_en[p]   = 1'b1;
        wr_addr[p] = clr_cnt;
        wr_data[p] = '0;
      end else if (s1_adv && !s1.first && (s1.behind[0] == p[0])) begin
        wr_en[p]   = 1'b1;
        wr_addr[p] = {~s1.odd, b_half[HW-1:0]};
        wr_data[p] = behind_word;
      end else if (s1_adv && s1.last && (s1.x[0] == p[0])) begin
        wr_en[p]   = 1'b1;
        wr_addr[p] = {~s1.odd, x_half[HW-1:0]};
        wr_data[p] = below_word;
      end else begin
        wr_en[p]   = 1'b0;
        wr_addr[p] = {~s1.odd, x_half[HW-1:0]};
        wr_data[p] = below_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 3; c++) begin
        carry[c]       <= '0;
        pend_ahead[c]  <= '0;
        pend_behind[c] <= '0;
      end
    end else if (s1_adv) begin
      for (int c = 0; c < 3; c++) begin
        carry[c]       <= carry_next[c];
        pend_ahead[c]  <= pend_ahead_next[c];
        pend_behind[c] <= pend_behind_next[c];
      end
    end
  end

  assign col_ext = (CW + COLW)'(s1.x);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      palette_index <= {level[0], level[1], level[2][1:0]};
      column        <= col_ext[COLW-1:0];
      last_in_line  <= s1.last;
    end
  end

endmodule

>>> bench/serpentine_error_diffusion_rgb332_tb.sv
// Self-checking bench for the serpentine RGB332 dither block: table and random streams.
`timescale 1ns / 1ps

module serpentine_error_diffusion_rgb332_tb;

  localparam int MAX_LINE_WIDTH = sed_pkg::MAX_LINE_WIDTH;
  localparam int ERROR_BITS     = sed_pkg::ERROR_BITS;
  localparam int CFG_BITS       = sed_pkg::CFG_BITS;
  localparam int COLUMN_BITS    = sed_pkg::COLUMN_BITS;
  localparam int ERR_HI         = (1 << (ERROR_BITS - 1)) - 1;
  localparam int ERR_LO         = -ERR_HI - 1;
  localparam int RANDOM_PIXELS  = 1050;
  localparam int SQUEEZE_AT     = 400;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 10000;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       odd;
    logic       img;
  } pix_t;

  typedef struct packed {
    logic [7:0]             idx;
    logic [COLUMN_BITS-1:0] col;
    logic                   last;
  } res_t;

  typedef struct packed {
    logic                is_cfg;
    logic [CFG_BITS-1:0] cfg_val;
    pix_t                px;
    logic                typed;
    res_t                want;
  } step_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_BITS-1:0]    cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             red;
  logic [7:0]             green;
  logic [7:0]             blue;
  logic                   row_odd;
  logic                   new_image;
  logic                   out_valid;
  logic                   out_ready;
  logic [7:0]             palette_index;
  logic [COLUMN_BITS-1:0] column;
  logic                   last_in_line;

  serpentine_error_diffusion_rgb332 dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .row_odd      (row_odd),
    .new_image    (new_image),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .palette_index(palette_index),
    .column       (column),
    .last_in_line (last_in_line)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Predictor state: line error stores, right-hand carry, pending below sums
  int                  err_mem [2][MAX_LINE_WIDTH][3];
  int                  carry [3];
  int                  below_cur [3];
  int                  below_next [3];
  int unsigned         line_pos;
  logic [CFG_BITS-1:0] width_reg;

  res_t  awaited[$];
  step_t plan[$];
  bit    calm;
  bit    squeeze_req;
  int    mismatches;
  int    pixels_sent;
  int    results_seen;
  int    width_settings;

  function automatic void reset_model();
    foreach (err_mem[i, j, k]) err_mem[i][j][k] = 0;
    for (int ch = 0; ch < 3; ch++) begin
      carry[ch] = 0;
      below_cur[ch] = 0;
      below_next[ch] = 0;
    end
    line_pos = 0;
    width_reg = sed_pkg::LINE_WIDTH_RESET;
  endfunction

  function automatic int unsigned span();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_LINE_WIDTH) return MAX_LINE_WIDTH;
    return 32'(width_reg);
  endfunction

  function automatic int clip_err(int v);
    if (v > ERR_HI) return ERR_HI;
    if (v < ERR_LO) return ERR_LO;
    return v;
  endfunction

  function automatic res_t dither_pixel(pix_t p);
    int unsigned w, lx, x, behind;
    int pix, e, t, lvl, act, q, p0, maxl, sh;
    int lev [3];
    res_t r;
    w = span();
    lx = line_pos;
    if (lx >= w) lx = 0;
    x = p.odd ? (w - 1 - lx) : lx;
    behind = 0;
    if (lx > 0) behind = p.odd ? x + 1 : x - 1;
    if (lx == 0) begin
      for (int ch = 0; ch < 3; ch++) begin
        carry[ch] = 0;
        below_next[ch] = 0;
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      pix = (ch == 0) ? int'(p.r) : (ch == 1) ? int'(p.g) : int'(p.b);
      sh = (ch == 2) ? 6 : 5;
      maxl = (ch == 2) ? 3 : 7;
      e = p.img ? 0 : err_mem[p.odd][x][ch];
      e = clip_err(e + carry[ch]);
      t = pix + ((e + 8) >>> 4);
      lvl = t >>> sh;
      if (lvl < 0) lvl = 0;
      if (lvl > maxl) lvl = maxl;
      act = lvl * 255 / maxl;
      q = t - act;
      lev[ch] = lvl;
      carry[ch] = clip_err(7 * q);
      // below-behind neighbour of the line's first pixel is dropped
      if (lx > 0) err_mem[p.odd ^ 1'b1][behind][ch] = clip_err(below_cur[ch] + 3 * q);
      p0 = below_next[ch] + 5 * q;
      below_next[ch] = q;
      below_cur[ch] = p0;
      if (lx == w - 1) err_mem[p.odd ^ 1'b1][x][ch] = clip_err(p0);
    end
    r.idx  = 8'(lev[0] * 32 + lev[1] * 4 + lev[2]);
    r.col  = COLUMN_BITS'(x);
    r.last = (lx == w - 1);
    line_pos = lx + 1;
    if (line_pos >= w) line_pos = 0;
    return r;
  endfunction

  function automatic logic [7:0] draw_level();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_cfg(int v);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.cfg_val = CFG_BITS'(v);
    plan.push_back(s);
  endfunction

  function automatic void add_px(int r, int g, int b, bit odd, bit img);
    step_t s;
    s = '0;
    s.px = '{r: 8'(r), g: 8'(g), b: 8'(b), odd: odd, img: img};
    plan.push_back(s);
  endfunction

  function automatic void add_known(int r, int g, int b, bit odd, bit img,
                                    int idx, int col, bit last);
    add_px(r, g, b, odd, img);
    plan[$].typed = 1'b1;
    plan[$].want = '{idx: 8'(idx), col: COLUMN_BITS'(col), last: last};
  endfunction

  task automatic offer_pixel(input pix_t p, input bit typed, input res_t want);
    res_t exp_res;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    red       <= p.r;
    green     <= p.g;
    blue      <= p.b;
    row_odd   <= p.odd;
    new_image <= p.img;
    do @(posedge clk); while (!in_ready);
    // transfer taken at this edge
    exp_res = dither_pixel(p);
    awaited.push_back(typed ? want : exp_res);
    pixels_sent++;
    if (pixels_sent == SQUEEZE_AT) squeeze_req = 1'b1;
  endtask

  task automatic set_line_width(input logic [CFG_BITS-1:0] v);
    in_valid <= 1'b0;
    // hold the write until the pipeline has drained
    while (awaited.size() != 0) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg = v;
    line_pos = 0;
    width_settings++;
  endtask

  task automatic run_image(input logic [CFG_BITS-1:0] w_cfg, input int rows,
                           input bit fresh_start);
    int unsigned w;
    pix_t p;
    set_line_width(w_cfg);
    w = span();
    for (int row = 0; row < rows; row++) begin
      for (int i = 0; i < int'(w); i++) begin
        p.r = draw_level();
        p.g = draw_level();
        p.b = draw_level();
        p.odd = row[0];
        p.img = (row == 0) && fresh_start;
        // occasional broken sequencing: stray parity or image flag
        if ($urandom_range(0, 19) == 0) begin
          p.odd = 1'($urandom_range(0, 1));
          p.img = 1'($urandom_range(0, 1));
        end
        offer_pixel(p, 1'b0, '0);
      end
    end
  endtask

  function automatic void check_result();
    res_t e;
    results_seen++;
    if (awaited.size() == 0) begin
      $error("unexpected result: palette_index %0d column %0d last_in_line %0d",
             palette_index, column, last_in_line);
      mismatches++;
      return;
    end
    e = awaited.pop_front();
    if (palette_index !== e.idx) begin
      $error("palette_index: expected %0d, actual %0d", e.idx, palette_index);
      mismatches++;
    end
    if (column !== e.col) begin
      $error("column: expected %0d, actual %0d", e.col, column);
      mismatches++;
    end
    if (last_in_line !== e.last) begin
      $error("last_in_line: expected %0d, actual %0d", e.last, last_in_line);
      mismatches++;
    end
  endfunction

  initial begin : drain
    int stall;
    int hold_left;
    stall = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_result();
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (squeeze_req) begin
        // long back-pressure: let the block fill and stall its input
        squeeze_req = 1'b0;
        hold_left = SQUEEZE_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 6) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned w;
    int rows;
    int random_goal;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    red       <= '0;
    green     <= '0;
    blue      <= '0;
    row_odd   <= 1'b0;
    new_image <= 1'b0;
    calm = 1'b0;
    squeeze_req = 1'b0;
    mismatches = 0;
    pixels_sent = 0;
    results_seen = 0;
    width_settings = 0;
    reset_model();

    // width after reset is 640
    add_known(0, 0, 0, 1'b0, 1'b1, 'h00, 0, 1'b0);
    add_known(0, 0, 0, 1'b1, 1'b1, 'h00, 638, 1'b0);
    // zero acts as a one-pixel line: every pixel starts and ends a line
    add_cfg(0);
    add_known(0, 0, 0, 1'b0, 1'b1, 'h00, 0, 1'b1);
    add_known(255, 255, 255, 1'b1, 1'b1, 'hFF, 0, 1'b1);
    add_known(255, 0, 0, 1'b0, 1'b1, 'hE0, 0, 1'b1);
    add_known(0, 255, 0, 1'b1, 1'b1, 'h1C, 0, 1'b1);
    add_known(0, 0, 255, 1'b0, 1'b1, 'h03, 0, 1'b1);
    add_known(31, 31, 63, 1'b0, 1'b1, 'h00, 0, 1'b1);
    add_known(32, 32, 64, 1'b1, 1'b1, 'h25, 0, 1'b1);
    add_px(200, 100, 50, 1'b0, 1'b0);
    add_px(255, 255, 255, 1'b1, 1'b0);
    // oversized width clamps to the maximum line
    add_cfg(2047);
    add_known(0, 0, 0, 1'b1, 1'b1, 'h00, MAX_LINE_WIDTH - 1, 1'b0);
    add_px(255, 255, 255, 1'b1, 1'b1);
    add_px(0, 0, 0, 1'b1, 1'b1);
    add_cfg(3);
    add_px(255, 0, 128, 1'b0, 1'b1);
    add_px(0, 255, 128, 1'b0, 1'b1);
    add_px(128, 128, 128, 1'b0, 1'b1);
    add_px(10, 250, 3, 1'b1, 1'b0);
    add_px(250, 10, 252, 1'b1, 1'b0);
    add_px(128, 64, 192, 1'b1, 1'b0);
    // parity flips inside one line
    add_px(90, 90, 90, 1'b0, 1'b0);
    add_px(90, 90, 90, 1'b1, 1'b0);
    add_px(90, 90, 90, 1'b0, 1'b0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_line_width(plan[i].cfg_val);
      else offer_pixel(plan[i].px, plan[i].typed, plan[i].want);
    end

    random_goal = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < random_goal) begin
      case ($urandom_range(0, 9))
        0: w = 0;
        1: w = 1;
        2: w = 2;
        9: w = $urandom_range(25, 90);
        default: w = $urandom_range(3, 24);
      endcase
      rows = (w > 24) ? 2 : $urandom_range(2, 8);
      run_image(CFG_BITS'(w), rows, $urandom_range(0, 7) != 0);
    end

    // drop all idling for the closing stretch
    calm = 1'b1;
    run_image(CFG_BITS'(7), 12, 1'b1);

    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Dithered %0d pixels across %0d line-width settings, %0d results checked.",
             pixels_sent, width_settings, results_seen);
    $display("Widths ran from zero and one up past the maximum, with stalls and a long hold.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
